// ===== src/assert_macros.svh =====
// assertion helpers, compiled out for synthesis
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// ante holds -> cons holds in the same cycle
`define LOLE_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("same-cycle implication violated");

// ante holds -> cons holds in the next cycle
`define LOLE_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle implication violated");

// expr never holds
`define LOLE_ASSERT_NEVER(lbl, clk, rst_n, expr) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
        else $error("forbidden condition seen");

`else

`define LOLE_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define LOLE_ASSERT_NXT(lbl, clk, rst_n, ante, cons)
`define LOLE_ASSERT_NEVER(lbl, clk, rst_n, expr)

`endif

`endif

// ===== src/lole_pkg.sv =====
`default_nettype none

package lole_pkg;

    localparam int BOX_W      = 11;
    localparam int TYPE_W     = 3;
    localparam int SUM_W      = 20;
    localparam int CFG_DATA_W = 32;
    localparam int CFG_ADDR_W = 3;

    // register index taken from paddr[2]
    localparam logic REG_BOX_COUNT = 1'b0;

    localparam logic [BOX_W-1:0] BOX_COUNT_RESET = 11'd1;

    typedef enum logic [TYPE_W-1:0] {
        REQ_INIT    = 3'd0,
        REQ_MOVE_L  = 3'd1,
        REQ_MOVE_R  = 3'd2,
        REQ_SWAP    = 3'd3,
        REQ_REVERSE = 3'd4,
        REQ_QUERY   = 3'd5
    } req_code_t;

endpackage

`default_nettype wire

// ===== src/lole_link_ram.sv =====
`default_nettype none

module lole_link_ram #(
    parameter int DEPTH = 1025,
    parameter int AW    = 11,
    parameter int DW    = 11
) (
    input  wire logic          clk,
    input  wire logic          we,
    input  wire logic [AW-1:0] waddr,
    input  wire logic [DW-1:0] wdata,
    input  wire logic [AW-1:0] raddr,
    output logic      [DW-1:0] rdata
);

    logic [DW-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // registered read, old data on a same-address collision
    always_ff @(posedge clk)
    begin
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

// ===== src/linked_order_list_engine.sv =====
// linked_order_list_engine: ordered line of boxes 1..n kept as a circular
// doubly linked list in two link memories (next and prev), sentinel at 0.
// requests come in on the req channel (req_valid/req_ready with req_type,
// box_x, box_y); a query returns one item on the rsp channel
// (rsp_valid/rsp_ready with odd_position_sum), all other requests none.
// box_count is written over the apb port at byte address 0; the user must do
// so only while idle, the block itself does not enforce it. one request is
// worked at a time; req_ready is high only when idle. work per request:
//   reverse, unused codes and bad boxes: done at accept, moves in place:
//     read x, read y, decide; move left/right: three joins, swap: three
//     (adjacent) or four joins (read x, read y, decide, then one link
//     write pair per join); initialize: one entry of each memory written
//     per cycle, 0 to n; query: one next-link read per visited box (the read
//     data feeds the next read address, so the walk is one box a cycle)
// the query result sits in an output register; the engine goes on taking
// requests while it waits, but a second query result holds the engine in
// its last state until the first one is taken.
// reset clears the control state, sets box_count to 1 and clears the
// reverse flag; the link memories are not cleared, an initialize request
// must come first.
`default_nettype none
`include "assert_macros.svh"

module linked_order_list_engine #(
    parameter int MAX_BOXES = 1024
) (
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    // config port
    input  wire logic                                 psel,
    input  wire logic                                 penable,
    input  wire logic                                 pwrite,
    input  wire logic [lole_pkg::CFG_ADDR_W-1:0]      paddr,
    input  wire logic [lole_pkg::CFG_DATA_W-1:0]      pwdata,
    output logic      [lole_pkg::CFG_DATA_W-1:0]      prdata,
    output logic                                      pready,
    // request channel
    input  wire logic                                 req_valid,
    output logic                                      req_ready,
    input  wire logic [lole_pkg::TYPE_W-1:0]          req_type,
    input  wire logic [lole_pkg::BOX_W-1:0]           box_x,
    input  wire logic [lole_pkg::BOX_W-1:0]           box_y,
    // response channel
    output logic                                      rsp_valid,
    input  wire logic                                 rsp_ready,
    output logic      [lole_pkg::SUM_W-1:0]           odd_position_sum
);

    localparam int DEPTH = MAX_BOXES + 1;
    localparam int AW    = $clog2(DEPTH);
    localparam int BW    = lole_pkg::BOX_W;
    localparam int SW    = lole_pkg::SUM_W;
    localparam int PW    = 2 * BW;

    typedef enum logic [2:0] {
        S_IDLE,
        S_RDY,
        S_CALC,
        S_WR,
        S_INIT,
        S_QWALK,
        S_QOUT
    } state_t;

    // ---------------- registers ----------------
    state_t              state_reg, state_next;
    logic [BW-1:0]       box_count_reg, box_count_next;
    logic                rev_reg, rev_next;
    logic                rsp_valid_reg, rsp_valid_next;
    logic [SW-1:0]       rsp_sum_reg, rsp_sum_next;
    logic [2:0]          jcnt_reg, jcnt_next;

    lole_pkg::req_code_t op_reg, op_next;
    logic [AW-1:0]       x_reg, x_next;
    logic [AW-1:0]       y_reg, y_next;
    logic [AW-1:0]       nx_reg, nx_next;
    logic [AW-1:0]       px_reg, px_next;
    logic [BW-1:0]       n_reg, n_next;
    logic [BW-1:0]       idx_reg, idx_next;
    logic [SW-1:0]       sum_reg, sum_next;
    logic [SW-1:0]       tri_reg, tri_next;
    logic [AW-1:0]       ja_reg [4];
    logic [AW-1:0]       jb_reg [4];
    logic [AW-1:0]       ja_next [4];
    logic [AW-1:0]       jb_next [4];

    // ---------------- memory ports ----------------
    logic                next_we, prev_we;
    logic [AW-1:0]       next_waddr, prev_waddr;
    logic [AW-1:0]       next_wdata, prev_wdata;
    logic [AW-1:0]       next_raddr, prev_raddr;
    logic [AW-1:0]       next_rdata, prev_rdata;

    lole_link_ram #(
        .DEPTH (DEPTH),
        .AW    (AW),
        .DW    (AW)
    ) u_next_ram (
        .clk   (clk),
        .we    (next_we),
        .waddr (next_waddr),
        .wdata (next_wdata),
        .raddr (next_raddr),
        .rdata (next_rdata)
    );

    lole_link_ram #(
        .DEPTH (DEPTH),
        .AW    (AW),
        .DW    (AW)
    ) u_prev_ram (
        .clk   (clk),
        .we    (prev_we),
        .waddr (prev_waddr),
        .wdata (prev_wdata),
        .raddr (prev_raddr),
        .rdata (prev_rdata)
    );

    // ---------------- config port ----------------
    logic cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite
                    && (paddr[2] == lole_pkg::REG_BOX_COUNT);
    assign prdata = (paddr[2] == lole_pkg::REG_BOX_COUNT)
                    ? lole_pkg::CFG_DATA_W'(box_count_reg) : '0;

    always_comb
    begin
        box_count_next = box_count_reg;
        if (cfg_wr)
        begin
            box_count_next = pwdata[BW-1:0];
        end
    end

    // effective box count, capped at MAX_BOXES, the largest line the memories hold
    logic [BW-1:0] eff_n;
    logic [PW-1:0] tri_prod;

    assign eff_n = (32'(box_count_reg) > 32'(MAX_BOXES)) ? BW'(MAX_BOXES) : box_count_reg;
    // n(n+1), halved by dropping bit 0
    assign tri_prod = PW'(eff_n) * PW'(eff_n + 12'd1);

    // accept-time checks on move and swap boxes
    logic boxes_ok;
    assign boxes_ok = (box_x != box_y) && (box_x != '0) && (box_y != '0)
                      && (box_x <= eff_n) && (box_y <= eff_n);

    // ---------------- relink decision ----------------
    // x data was captured in nx/px, y data is on the memory outputs
    logic [AW-1:0] calc_a [4];
    logic [AW-1:0] calc_b [4];
    logic [2:0]    calc_cnt;

    always_comb
    begin
        logic [AW-1:0]       cx, cy, lx, rx, ly, ry;
        lole_pkg::req_code_t cop;
        cx  = x_reg;
        cy  = y_reg;
        lx  = px_reg;
        rx  = nx_reg;
        ly  = prev_rdata;
        ry  = next_rdata;
        // swap with y directly before x: trade roles so x comes first
        if (op_reg == lole_pkg::REQ_SWAP && next_rdata == x_reg)
        begin
            cx = y_reg;
            cy = x_reg;
            lx = prev_rdata;
            rx = next_rdata;
            ly = px_reg;
            ry = nx_reg;
        end
        cop = op_reg;
        // reversed line mirrors left and right
        if (op_reg != lole_pkg::REQ_SWAP && rev_reg)
        begin
            cop = (op_reg == lole_pkg::REQ_MOVE_L) ? lole_pkg::REQ_MOVE_R
                                                   : lole_pkg::REQ_MOVE_L;
        end
        for (int i = 0; i < 4; i++)
        begin
            calc_a[i] = '0;
            calc_b[i] = '0;
        end
        calc_cnt = 3'd0;
        case (cop)
            lole_pkg::REQ_MOVE_L:
            begin
                if (cx != ly)
                begin
                    calc_a[0] = lx; calc_b[0] = rx;
                    calc_a[1] = ly; calc_b[1] = cx;
                    calc_a[2] = cx; calc_b[2] = cy;
                    calc_cnt  = 3'd3;
                end
            end
            lole_pkg::REQ_MOVE_R:
            begin
                if (cx != ry)
                begin
                    calc_a[0] = lx; calc_b[0] = rx;
                    calc_a[1] = cy; calc_b[1] = cx;
                    calc_a[2] = cx; calc_b[2] = ry;
                    calc_cnt  = 3'd3;
                end
            end
            lole_pkg::REQ_SWAP:
            begin
                if (rx == cy)
                begin
                    // adjacent boxes
                    calc_a[0] = lx; calc_b[0] = cy;
                    calc_a[1] = cy; calc_b[1] = cx;
                    calc_a[2] = cx; calc_b[2] = ry;
                    calc_cnt  = 3'd3;
                end
                else
                begin
                    calc_a[0] = lx; calc_b[0] = cy;
                    calc_a[1] = cy; calc_b[1] = rx;
                    calc_a[2] = ly; calc_b[2] = cx;
                    calc_a[3] = cx; calc_b[3] = ry;
                    calc_cnt  = 3'd4;
                end
            end
            default:
            begin
                calc_cnt = 3'd0;
            end
        endcase
    end

    // ---------------- main control ----------------
    logic req_acc;
    assign req_acc = req_valid && req_ready;

    always_comb
    begin
        logic [SW-1:0] final_sum;
        final_sum      = (rev_reg && !n_reg[0]) ? (tri_reg - sum_reg) : sum_reg;

        state_next     = state_reg;
        rev_next       = rev_reg;
        rsp_valid_next = rsp_valid_reg && !rsp_ready;
        rsp_sum_next   = rsp_sum_reg;
        jcnt_next      = jcnt_reg;
        op_next        = op_reg;
        x_next         = x_reg;
        y_next         = y_reg;
        nx_next        = nx_reg;
        px_next        = px_reg;
        n_next         = n_reg;
        idx_next       = idx_reg;
        sum_next       = sum_reg;
        tri_next       = tri_reg;
        for (int i = 0; i < 4; i++)
        begin
            ja_next[i] = ja_reg[i];
            jb_next[i] = jb_reg[i];
        end

        next_we    = 1'b0;
        prev_we    = 1'b0;
        next_waddr = '0;
        prev_waddr = '0;
        next_wdata = '0;
        prev_wdata = '0;
        next_raddr = '0;
        prev_raddr = '0;

        case (state_reg)
            S_IDLE:
            begin
                // x links are read during the accept cycle
                next_raddr = (req_type == lole_pkg::REQ_QUERY) ? '0 : AW'(box_x);
                prev_raddr = AW'(box_x);
                if (req_acc)
                begin
                    op_next  = lole_pkg::req_code_t'(req_type);
                    x_next   = AW'(box_x);
                    y_next   = AW'(box_y);
                    n_next   = eff_n;
                    idx_next = '0;
                    sum_next = '0;
                    tri_next = tri_prod[SW:1];
                    case (lole_pkg::req_code_t'(req_type))
                        lole_pkg::REQ_INIT:
                        begin
                            rev_next   = 1'b0;
                            state_next = S_INIT;
                        end
                        lole_pkg::REQ_MOVE_L,
                        lole_pkg::REQ_MOVE_R,
                        lole_pkg::REQ_SWAP:
                        begin
                            if (boxes_ok)
                            begin
                                state_next = S_RDY;
                            end
                        end
                        lole_pkg::REQ_REVERSE:
                        begin
                            rev_next = !rev_reg;
                        end
                        lole_pkg::REQ_QUERY:
                        begin
                            idx_next   = BW'(1);
                            state_next = (eff_n == '0) ? S_QOUT : S_QWALK;
                        end
                        default:
                        begin
                            state_next = S_IDLE;
                        end
                    endcase
                end
            end

            S_RDY:
            begin
                nx_next    = next_rdata;
                px_next    = prev_rdata;
                next_raddr = y_reg;
                prev_raddr = y_reg;
                state_next = S_CALC;
            end

            S_CALC:
            begin
                for (int i = 0; i < 4; i++)
                begin
                    ja_next[i] = calc_a[i];
                    jb_next[i] = calc_b[i];
                end
                jcnt_next  = calc_cnt;
                state_next = (calc_cnt == 3'd0) ? S_IDLE : S_WR;
            end

            S_WR:
            begin
                // join(a, b): next[a] = b, prev[b] = a
                next_we    = 1'b1;
                next_waddr = ja_reg[0];
                next_wdata = jb_reg[0];
                prev_we    = 1'b1;
                prev_waddr = jb_reg[0];
                prev_wdata = ja_reg[0];
                for (int i = 0; i < 3; i++)
                begin
                    ja_next[i] = ja_reg[i+1];
                    jb_next[i] = jb_reg[i+1];
                end
                jcnt_next = jcnt_reg - 3'd1;
                if (jcnt_reg == 3'd1)
                begin
                    state_next = S_IDLE;
                end
            end

            S_INIT:
            begin
                next_we    = 1'b1;
                prev_we    = 1'b1;
                next_waddr = AW'(idx_reg);
                prev_waddr = AW'(idx_reg);
                if (idx_reg == '0)
                begin
                    next_wdata = (n_reg == '0) ? '0 : AW'(1);
                    prev_wdata = AW'(n_reg);
                end
                else
                begin
                    next_wdata = (idx_reg == n_reg) ? '0 : AW'(idx_reg + BW'(1));
                    prev_wdata = AW'(idx_reg - BW'(1));
                end
                idx_next = idx_reg + BW'(1);
                if (idx_reg == n_reg)
                begin
                    state_next = S_IDLE;
                end
            end

            S_QWALK:
            begin
                // memory output is the box at position idx
                next_raddr = next_rdata;
                if (idx_reg[0])
                begin
                    sum_next = sum_reg + SW'(next_rdata);
                end
                idx_next = idx_reg + BW'(1);
                if (idx_reg == n_reg)
                begin
                    state_next = S_QOUT;
                end
            end

            S_QOUT:
            begin
                if (!rsp_valid_reg || rsp_ready)
                begin
                    rsp_valid_next = 1'b1;
                    rsp_sum_next   = final_sum;
                    state_next     = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // state and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            box_count_reg <= lole_pkg::BOX_COUNT_RESET;
            rev_reg       <= 1'b0;
            rsp_valid_reg <= 1'b0;
            jcnt_reg      <= 3'd0;
        end
        else
        begin
            state_reg     <= state_next;
            box_count_reg <= box_count_next;
            rev_reg       <= rev_next;
            rsp_valid_reg <= rsp_valid_next;
            jcnt_reg      <= jcnt_next;
        end
    end

    // payload, no reset
    always_ff @(posedge clk)
    begin
        rsp_sum_reg <= rsp_sum_next;
        op_reg      <= op_next;
        x_reg       <= x_next;
        y_reg       <= y_next;
        nx_reg      <= nx_next;
        px_reg      <= px_next;
        n_reg       <= n_next;
        idx_reg     <= idx_next;
        sum_reg     <= sum_next;
        tri_reg     <= tri_next;
        for (int i = 0; i < 4; i++)
        begin
            ja_reg[i] <= ja_next[i];
            jb_reg[i] <= jb_next[i];
        end
    end

    assign req_ready        = (state_reg == S_IDLE);
    assign rsp_valid        = rsp_valid_reg;
    assign odd_position_sum = rsp_sum_reg;

    // ---------------- checks ----------------
    // the walk only reads the links
    `LOLE_ASSERT_IMP(a_walk_no_write, clk, rst_n, state_reg == S_QWALK, !next_we && !prev_we)
    // a write pass always has a join pending
    `LOLE_ASSERT_IMP(a_wr_has_join, clk, rst_n, state_reg == S_WR, jcnt_reg != 3'd0)
    // the init sweep stays inside the line
    `LOLE_ASSERT_IMP(a_init_in_range, clk, rst_n, state_reg == S_INIT, idx_reg <= n_reg)
    // a new result only ever comes from the end of a query
    `LOLE_ASSERT_NXT(a_rsp_from_query, clk, rst_n, !rsp_valid_reg && state_reg != S_QOUT, !rsp_valid_reg)

endmodule

`default_nettype wire

// ===== bench/tb_linked_order_list_engine.sv =====
`timescale 1ns / 1ps

module tb_linked_order_list_engine;

    localparam int CLK_PERIOD      = 10;
    localparam int RESET_CYCLES    = 6;
    localparam int LINE_MAX        = 1024;
    localparam int BOX_W           = lole_pkg::BOX_W;
    localparam int TYPE_W          = lole_pkg::TYPE_W;
    localparam int SUM_W           = lole_pkg::SUM_W;
    localparam int CFG_ADDR_W      = lole_pkg::CFG_ADDR_W;
    localparam int CFG_DATA_W      = lole_pkg::CFG_DATA_W;
    localparam int COUNT_FIELD_MAX = 2**BOX_W - 1;
    // cycles with nothing accepted before the run is called hung
    localparam int QUIET_LIMIT     = 20000;
    // long receiver hold-off used to back the engine up
    localparam int HOLD_CYCLES     = 400;

    // codes the engine has no request for, they must be dropped
    localparam logic [TYPE_W-1:0] REQ_SPARE_A = 3'd6;
    localparam logic [TYPE_W-1:0] REQ_SPARE_B = 3'd7;

    // box_count register sits at register index 0
    localparam logic [CFG_ADDR_W-1:0] BOX_COUNT_ADDR = {lole_pkg::REG_BOX_COUNT, 2'b00};

    // tracks the box line and the sums that queries must return
    class line_tracker;
        logic [BOX_W-1:0] next_box [LINE_MAX+1];
        logic [BOX_W-1:0] prev_box [LINE_MAX+1];
        logic             flipped;
        logic [BOX_W-1:0] count_reg;
        int               built_count;
        logic [SUM_W-1:0] sums_due [$];
        int               failures;

        function new();
            foreach (next_box[i])
            begin
                next_box[i] = '0;
                prev_box[i] = '0;
            end
            flipped     = 1'b0;
            count_reg   = lole_pkg::BOX_COUNT_RESET;
            built_count = -1;
            failures    = 0;
        endfunction

        function int live_count();
            return (count_reg > LINE_MAX) ? LINE_MAX : int'(count_reg);
        endfunction

        function void set_count(int value);
            count_reg = BOX_W'(value);
        endfunction

        function void join_boxes(int a, int b);
            next_box[a] = BOX_W'(b);
            prev_box[b] = BOX_W'(a);
        endfunction

        function void build(int n);
            int i;
            for (i = 1; i <= n; i++)
            begin
                prev_box[i] = BOX_W'(i - 1);
                next_box[i] = BOX_W'((i == n) ? 0 : i + 1);
            end
            next_box[0] = BOX_W'((n == 0) ? 0 : 1);
            prev_box[0] = BOX_W'(n);
            flipped     = 1'b0;
            built_count = n;
        endfunction

        function void relink(lole_pkg::req_code_t op, int x, int y);
            int lx;
            int rx;
            int ly;
            int ry;
            int t;
            // adjacent swap given in the other order
            if (op == lole_pkg::REQ_SWAP && next_box[y] == x)
            begin
                t = x;
                x = y;
                y = t;
            end
            // a reversed line mirrors left and right
            if (op != lole_pkg::REQ_SWAP && flipped)
                op = (op == lole_pkg::REQ_MOVE_L) ? lole_pkg::REQ_MOVE_R
                                                  : lole_pkg::REQ_MOVE_L;
            if (op == lole_pkg::REQ_MOVE_L && x == prev_box[y])
                return;
            if (op == lole_pkg::REQ_MOVE_R && x == next_box[y])
                return;
            lx = prev_box[x];
            rx = next_box[x];
            ly = prev_box[y];
            ry = next_box[y];
            if (op == lole_pkg::REQ_MOVE_L)
            begin
                join_boxes(lx, rx);
                join_boxes(ly, x);
                join_boxes(x, y);
            end
            else if (op == lole_pkg::REQ_MOVE_R)
            begin
                join_boxes(lx, rx);
                join_boxes(y, x);
                join_boxes(x, ry);
            end
            else if (rx == y)
            begin
                join_boxes(lx, y);
                join_boxes(y, x);
                join_boxes(x, ry);
            end
            else
            begin
                join_boxes(lx, y);
                join_boxes(y, rx);
                join_boxes(ly, x);
                join_boxes(x, ry);
            end
        endfunction

        function logic [SUM_W-1:0] odd_sum();
            int          n;
            int          b;
            int          i;
            logic [63:0] total;
            n     = live_count();
            b     = 0;
            total = '0;
            for (i = 1; i <= n; i++)
            begin
                b = next_box[b];
                if (i % 2 == 1)
                    total += 64'(b);
            end
            if (flipped && n % 2 == 0)
                total = 64'(n * (n + 1) / 2) - total;
            return total[SUM_W-1:0];
        endfunction

        function void note_request(logic [TYPE_W-1:0] kind, int x, int y);
            int n;
            n = live_count();
            case (kind)
                lole_pkg::REQ_INIT:
                    build(n);
                lole_pkg::REQ_MOVE_L, lole_pkg::REQ_MOVE_R, lole_pkg::REQ_SWAP:
                    if (!(x == y || x < 1 || y < 1 || x > n || y > n))
                        relink(lole_pkg::req_code_t'(kind), x, y);
                lole_pkg::REQ_REVERSE:
                    flipped = !flipped;
                lole_pkg::REQ_QUERY:
                    sums_due.push_back(odd_sum());
                default:
                    ;
            endcase
        endfunction

        function void check_sum(logic [SUM_W-1:0] got);
            logic [SUM_W-1:0] want;
            if (sums_due.size() == 0)
            begin
                $display("%0t: odd_position_sum expected none, got %0d", $time, got);
                failures++;
            end
            else
            begin
                want = sums_due.pop_front();
                if (got !== want)
                begin
                    $display("%0t: odd_position_sum expected %0d, got %0d",
                             $time, want, got);
                    failures++;
                end
            end
        endfunction
    endclass

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [CFG_ADDR_W-1:0] paddr;
    logic [CFG_DATA_W-1:0] pwdata;
    logic [CFG_DATA_W-1:0] prdata;
    logic                  pready;
    logic                  req_valid;
    logic                  req_ready;
    logic [TYPE_W-1:0]     req_type;
    logic [BOX_W-1:0]      box_x;
    logic [BOX_W-1:0]      box_y;
    logic                  rsp_valid;
    logic                  rsp_ready;
    logic [SUM_W-1:0]      odd_position_sum;

    line_tracker board = new();

    // set by the stimulus, picked up by the receiver to start its long hold-off
    bit hold_rsp  = 1'b0;
    // items left in a run of back-to-back requests
    int burst_left = 0;
    int quiet_cycles = 0;

    linked_order_list_engine #(
        .MAX_BOXES(LINE_MAX)
    ) dut (
        .clk              (clk),
        .rst_n            (rst_n),
        .psel             (psel),
        .penable          (penable),
        .pwrite           (pwrite),
        .paddr            (paddr),
        .pwdata           (pwdata),
        .prdata           (prdata),
        .pready           (pready),
        .req_valid        (req_valid),
        .req_ready        (req_ready),
        .req_type         (req_type),
        .box_x            (box_x),
        .box_y            (box_y),
        .rsp_valid        (rsp_valid),
        .rsp_ready        (rsp_ready),
        .odd_position_sum (odd_position_sum)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    // gap before the next request: mostly none or short, now and then long,
    // with runs of back-to-back items mixed in
    function automatic int next_gap();
        int roll;
        if (burst_left > 0)
        begin
            burst_left--;
            return 0;
        end
        roll = $urandom_range(0, 99);
        if (roll < 3)
        begin
            burst_left = $urandom_range(20, 40);
            return 0;
        end
        if (roll < 50)
            return 0;
        if (roll < 85)
            return $urandom_range(1, 3);
        if (roll < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [TYPE_W-1:0] any_relink();
        case ($urandom_range(0, 2))
            0:       return lole_pkg::REQ_MOVE_L;
            1:       return lole_pkg::REQ_MOVE_R;
            default: return lole_pkg::REQ_SWAP;
        endcase
    endfunction

    // offer one item and hold it until the engine takes it; valid is left
    // high so that a following item with no gap goes out on the next cycle
    task automatic send_request(input logic [TYPE_W-1:0] kind, input int x,
                                input int y, input int gap);
        if (gap > 0)
        begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_valid <= 1'b1;
        req_type  <= kind;
        box_x     <= BOX_W'(x);
        box_y     <= BOX_W'(y);
        do
            @(posedge clk);
        while (!req_ready);
        board.note_request(kind, x, y);
    endtask

    // stop offering and wait for every query sum still owed
    task automatic drain_sums();
        req_valid <= 1'b0;
        while (board.sums_due.size() != 0)
            @(posedge clk);
    endtask

    // register write only while idle: drain, then let a full walk finish,
    // since an initialize may still be running without any result to show it
    task automatic write_box_count(input int value);
        logic [CFG_DATA_W-1:0] word;
        drain_sums();
        repeat (board.live_count() + 16) @(posedge clk);
        // junk above the 11-bit field must be dropped
        word = $urandom;
        word[BOX_W-1:0] = BOX_W'(value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= BOX_COUNT_ADDR;
        pwdata  <= word;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        board.set_count(value);
    endtask

    // one random item; counted is low for items the engine just drops
    task automatic send_random_request(output bit counted);
        int                n;
        int                roll;
        int                x;
        int                y;
        int                near;
        logic [TYPE_W-1:0] kind;
        n       = board.live_count();
        roll    = $urandom_range(0, 99);
        counted = 1'b1;
        x = (n > 0) ? $urandom_range(1, n) : 0;
        y = (n > 0) ? $urandom_range(1, n) : 0;
        if (n >= 2)
            while (y == x)
                y = $urandom_range(1, n);
        if (roll < 26)
            kind = lole_pkg::REQ_MOVE_L;
        else if (roll < 52)
            kind = lole_pkg::REQ_MOVE_R;
        else if (roll < 67)
            kind = lole_pkg::REQ_SWAP;
        else if (roll < 75)
            kind = lole_pkg::REQ_REVERSE;
        else if (roll < 87)
            kind = lole_pkg::REQ_QUERY;
        else if (roll < 90)
            kind = lole_pkg::REQ_INIT;
        else
        begin
            // noise: spare codes, equal boxes, boxes off the line
            counted = 1'b0;
            kind    = any_relink();
            case ($urandom_range(0, 3))
                0:
                begin
                    kind = $urandom_range(0, 1) ? REQ_SPARE_A : REQ_SPARE_B;
                    x    = $urandom_range(0, COUNT_FIELD_MAX);
                    y    = $urandom_range(0, COUNT_FIELD_MAX);
                end
                1:
                    y = x;
                2:
                    x = $urandom_range(0, 1) ? 0 : $urandom_range(n + 1, COUNT_FIELD_MAX);
                default:
                    y = $urandom_range(0, 1) ? 0 : $urandom_range(n + 1, COUNT_FIELD_MAX);
            endcase
        end
        // aim a quarter of the relinks at a neighbor: adjacent swaps and
        // moves that are already in place
        if (counted && (kind == lole_pkg::REQ_MOVE_L || kind == lole_pkg::REQ_MOVE_R
                        || kind == lole_pkg::REQ_SWAP)
            && n >= 2 && $urandom_range(0, 3) == 0)
        begin
            near = $urandom_range(0, 1) ? board.next_box[x] : board.prev_box[x];
            if (near != 0)
                y = near;
        end
        send_request(kind, x, y, next_gap());
    endtask

    // one setting of box_count and a stretch of random traffic under it
    task automatic run_phase(input int count, input int items, input bit squeeze);
        int done;
        bit counted;
        write_box_count(count);
        // links past the last initialize were never written, relink first
        if (board.live_count() > board.built_count || $urandom_range(0, 1))
            send_request(lole_pkg::REQ_INIT, $urandom_range(0, COUNT_FIELD_MAX),
                         $urandom_range(0, COUNT_FIELD_MAX), next_gap());
        done = 0;
        while (done < items)
        begin
            if (squeeze && done >= items / 2)
            begin
                squeeze = 1'b0;
                // sender waits for every owed sum, then the receiver holds off
                // while a string of queries backs the engine up
                drain_sums();
                hold_rsp = 1'b1;
                repeat (24)
                    send_request(lole_pkg::REQ_QUERY, $urandom_range(0, COUNT_FIELD_MAX),
                                 $urandom_range(0, COUNT_FIELD_MAX), 0);
            end
            send_random_request(counted);
            done += counted;
        end
    endtask

    // receiver: random stretches of ready high and low, one long hold-off
    // on request from the stimulus
    initial
    begin : rsp_side
        int roll;
        int stretch;
        logic level;
        rsp_ready <= 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            if (hold_rsp)
            begin
                hold_rsp = 1'b0;
                level    = 1'b0;
                stretch  = HOLD_CYCLES;
            end
            else
            begin
                roll = $urandom_range(0, 99);
                if (roll < 4)
                begin
                    level   = 1'b0;
                    stretch = $urandom_range(20, 80);
                end
                else if (roll < 35)
                begin
                    level   = 1'b0;
                    stretch = $urandom_range(1, 3);
                end
                else if (roll < 90)
                begin
                    level   = 1'b1;
                    stretch = $urandom_range(1, 12);
                end
                else
                begin
                    level   = 1'b1;
                    stretch = $urandom_range(50, 200);
                end
            end
            rsp_ready <= level;
            repeat (stretch)
            begin
                @(posedge clk);
                if (hold_rsp)
                    break;
            end
        end
    end

    // every sum taken off the response channel is checked in order
    always @(posedge clk)
    begin
        if (rst_n && rsp_valid && rsp_ready)
            board.check_sum(odd_position_sum);
    end

    // watchdog: too long with no item moving on any port
    always @(posedge clk)
    begin
        if (!rst_n || (req_valid && req_ready) || (rsp_valid && rsp_ready)
            || (psel && penable && pwrite))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("FAIL linked_order_list_engine");
            $finish;
        end
    end

    initial
    begin
        psel      <= 1'b0;
        penable   <= 1'b0;
        pwrite    <= 1'b0;
        paddr     <= '0;
        pwdata    <= '0;
        req_valid <= 1'b0;
        req_type  <= lole_pkg::REQ_INIT;
        box_x     <= '0;
        box_y     <= '0;
        rst_n     <= 1'b0;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;

        // reset count of one box
        send_request(lole_pkg::REQ_INIT, 0, 0, next_gap());
        send_request(lole_pkg::REQ_QUERY, 0, 0, next_gap());
        send_request(lole_pkg::REQ_MOVE_L, 1, 1, next_gap());

        // empty line: sentinel only, moves dropped, query gives zero
        write_box_count(0);
        send_request(lole_pkg::REQ_INIT, 0, 0, next_gap());
        send_request(lole_pkg::REQ_QUERY, 0, 0, next_gap());
        send_request(lole_pkg::REQ_MOVE_R, 1, 2, next_gap());

        // six boxes: in-place moves, real moves, both swap shapes,
        // mirrored move after reverse, complement on an even count
        write_box_count(6);
        send_request(lole_pkg::REQ_INIT, 0, 0, next_gap());
        send_request(lole_pkg::REQ_MOVE_L, 1, 2, next_gap());
        send_request(lole_pkg::REQ_MOVE_R, 2, 1, next_gap());
        send_request(lole_pkg::REQ_MOVE_L, 5, 2, next_gap());
        send_request(lole_pkg::REQ_MOVE_R, 1, 6, next_gap());
        send_request(lole_pkg::REQ_SWAP, 4, 3, next_gap());
        send_request(lole_pkg::REQ_SWAP, 2, 6, next_gap());
        send_request(lole_pkg::REQ_QUERY, 0, 0, next_gap());
        send_request(lole_pkg::REQ_REVERSE, 0, 0, next_gap());
        send_request(lole_pkg::REQ_MOVE_L, 3, 5, next_gap());
        send_request(lole_pkg::REQ_SWAP, 5, 0, next_gap());
        send_request(lole_pkg::REQ_QUERY, 0, 0, next_gap());
        send_request(REQ_SPARE_A, COUNT_FIELD_MAX, COUNT_FIELD_MAX, next_gap());
        send_request(REQ_SPARE_B, 0, 0, next_gap());
        send_request(lole_pkg::REQ_MOVE_L, COUNT_FIELD_MAX, 1, next_gap());
        send_request(lole_pkg::REQ_QUERY, 0, 0, next_gap());

        // count above the line size acts as the full line
        write_box_count(COUNT_FIELD_MAX);
        send_request(lole_pkg::REQ_INIT, 0, 0, next_gap());
        send_request(lole_pkg::REQ_REVERSE, 0, 0, next_gap());
        send_request(lole_pkg::REQ_QUERY, 0, 0, next_gap());

        // random traffic, small lines mostly, a few full-size phases;
        // lowering the count may keep the longer line from before
        run_phase(2, 150, 1'b0);
        run_phase(3, 150, 1'b0);
        run_phase(8, 250, 1'b0);
        run_phase(LINE_MAX, 60, 1'b0);
        run_phase(5, 200, 1'b0);
        run_phase(16, 250, 1'b1);
        run_phase(0, 20, 1'b0);
        run_phase(1, 30, 1'b0);
        run_phase(COUNT_FIELD_MAX, 40, 1'b0);
        repeat (3)
            run_phase($urandom_range(4, 40), 100, 1'b0);

        // all sums in, then room for a late stray result
        drain_sums();
        repeat (board.live_count() + 16) @(posedge clk);
        if (board.failures == 0)
            $display("PASS linked_order_list_engine");
        else
            $display("FAIL linked_order_list_engine");
        $finish;
    end

endmodule
